// ===== src/tms_pkg.sv =====
`timescale 1ns / 1ps

package tms_pkg;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_DIV,
    ST_PEND
  } tms_state_e;

  // configuration register indexes
  localparam logic CFG_TEMP_LIMIT = 1'b0;
  localparam logic CFG_TRIP_RUN   = 1'b1;

  localparam int unsigned LIMIT_BITS = 15;
  localparam int unsigned RUN_BITS   = 4;

  // register reset values
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 15'd1280;
  localparam logic [RUN_BITS-1:0]   TRIP_RESET  = 4'd3;

  // run length saturates here
  localparam logic [RUN_BITS-1:0]   RUN_MAX     = 4'd15;

  // request types
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_STOP   = 1'b1;

endpackage

// ===== src/tms_div.sv =====
`timescale 1ns / 1ps

module tms_div #(
  parameter int unsigned DvdBits = 40,
  parameter int unsigned DvsBits = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DvdBits-1:0] dividend_i,
  input  logic [DvsBits-1:0] divisor_i,
  output logic               done_o,
  output logic [DvdBits-1:0] quotient_o
);

  localparam int unsigned CntBits = (DvdBits > 1) ? $clog2(DvdBits) : 1;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic [DvdBits-1:0] quo_q, quo_d;
  logic [DvsBits-1:0] rem_q, rem_d;
  logic [DvsBits-1:0] dvs_q, dvs_d;

  logic [DvsBits:0]   trial;
  logic [DvsBits:0]   diff;
  logic               borrow;

  // one restoring step per cycle: shift in the next dividend bit and trial subtract
  assign trial  = {rem_q, quo_q[DvdBits-1]};
  assign diff   = trial - {1'b0, dvs_q};
  assign borrow = diff[DvsBits];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntBits'(DvdBits - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = borrow ? trial[DvsBits-1:0] : diff[DvsBits-1:0];
      quo_d = {quo_q[DvdBits-2:0], ~borrow};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== src/temperature_monitor_trip_stats.sv =====
`timescale 1ns / 1ps

// Over-temperature monitor with consecutive-trip shutdown and running statistics.
// An accepted sample request goes to ST_PEND, which loads the output register once
// it is free, and the input is ready again as that load happens. The request that
// halts the block (stop request, or the sample whose over-limit run reaches
// trip_run) with at least one sample recorded passes through ST_LAUNCH and ST_DIV
// before ST_PEND loads the output register: the mean comes from a restoring
// divider that settles one quotient bit per cycle over the magnitude of the
// running sum. Later requests take the ST_PEND path and are answered from the
// stored mean. The input is not ready while a request is in flight; a result
// held by output backpressure keeps the block in ST_PEND, so it delays both the
// next result and the next acceptance. Configuration writes are always taken
// and must be issued only while the block is idle.

module temperature_monitor_trip_stats #(
  parameter int unsigned COUNT_BITS = 24,
  parameter int unsigned TEMP_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         cfg_index_i,
  input  logic [tms_pkg::LIMIT_BITS-1:0] cfg_data_i,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         req_type_i,
  input  logic signed [TEMP_BITS-1:0]  temperature_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         over_limit_o,
  output logic [tms_pkg::RUN_BITS-1:0] run_length_o,
  output logic                         shutdown_o,
  output logic                         halted_o,
  output logic                         stats_valid_o,
  output logic [COUNT_BITS-1:0]        sample_total_o,
  output logic [COUNT_BITS-1:0]        above_total_o,
  output logic signed [TEMP_BITS-1:0]  max_temp_o,
  output logic signed [TEMP_BITS-1:0]  min_temp_o,
  output logic signed [TEMP_BITS-1:0]  mean_temp_o
);

  localparam int unsigned SumBits = COUNT_BITS + TEMP_BITS;
  localparam int unsigned CmpBits =
      ((TEMP_BITS > tms_pkg::LIMIT_BITS) ? TEMP_BITS : tms_pkg::LIMIT_BITS) + 1;

  // configuration registers
  logic [tms_pkg::LIMIT_BITS-1:0] limit_q, limit_d;
  logic [tms_pkg::RUN_BITS-1:0]   trip_q, trip_d;

  // monitor state
  logic [COUNT_BITS-1:0]       count_q, count_d;
  logic [COUNT_BITS-1:0]       over_cnt_q, over_cnt_d;
  logic signed [SumBits-1:0]   sum_q, sum_d;
  logic signed [TEMP_BITS-1:0] max_q, max_d;
  logic signed [TEMP_BITS-1:0] min_q, min_d;
  logic [tms_pkg::RUN_BITS-1:0] run_q, run_d;
  logic                        tripped_q, tripped_d;
  logic                        stopped_q, stopped_d;
  logic                        over_q, over_d;
  logic signed [TEMP_BITS-1:0] mean_q;

  tms_pkg::tms_state_e state_q, state_d;

  // output register
  logic                        out_valid_q;
  logic                        o_over_q;
  logic [tms_pkg::RUN_BITS-1:0] o_run_q;
  logic                        o_shut_q;
  logic                        o_halt_q;
  logic                        o_svalid_q;
  logic [COUNT_BITS-1:0]       o_count_q;
  logic [COUNT_BITS-1:0]       o_above_q;
  logic signed [TEMP_BITS-1:0] o_max_q;
  logic signed [TEMP_BITS-1:0] o_min_q;
  logic signed [TEMP_BITS-1:0] o_mean_q;

  logic                        in_acc;
  logic                        halted;
  logic                        div_needed;
  logic                        div_start;
  logic                        div_done;
  logic                        out_load;
  logic [SumBits-1:0]          sum_mag;
  logic [SumBits-1:0]          quotient;
  logic [TEMP_BITS-1:0]        quo_low;
  logic signed [CmpBits-1:0]   temp_ext;
  logic signed [CmpBits-1:0]   limit_ext;
  logic                        is_over;
  logic [tms_pkg::RUN_BITS-1:0] run_inc;
  logic [tms_pkg::RUN_BITS-1:0] need;

  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign halted      = tripped_q || stopped_q;

  // configuration writes
  always_comb begin
    limit_d = limit_q;
    trip_d  = trip_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        tms_pkg::CFG_TEMP_LIMIT: limit_d = cfg_data_i;
        tms_pkg::CFG_TRIP_RUN:   trip_d  = cfg_data_i[tms_pkg::RUN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // limit compare and run arithmetic
  assign temp_ext  = CmpBits'(temperature_i);
  assign limit_ext = $signed({{(CmpBits - tms_pkg::LIMIT_BITS){1'b0}}, limit_q});
  assign is_over   = temp_ext > limit_ext;
  assign run_inc   = (run_q == tms_pkg::RUN_MAX) ? run_q : run_q + 1'b1;
  assign need      = (trip_q == '0) ? tms_pkg::RUN_BITS'(1) : trip_q;

  // statistics update for an accepted request
  always_comb begin
    count_d    = count_q;
    over_cnt_d = over_cnt_q;
    sum_d      = sum_q;
    max_d      = max_q;
    min_d      = min_q;
    run_d      = run_q;
    tripped_d  = tripped_q;
    stopped_d  = stopped_q;
    over_d     = over_q;
    div_needed = 1'b0;
    if (in_acc) begin
      over_d = 1'b0;
      if (!halted) begin
        if (req_type_i == tms_pkg::REQ_STOP) begin
          stopped_d  = 1'b1;
          div_needed = (count_q != '0);
        end else begin
          if (count_q == '0 || temperature_i > max_q) max_d = temperature_i;
          if (count_q == '0 || temperature_i < min_q) min_d = temperature_i;
          if (count_q != '1) begin
            sum_d   = sum_q + SumBits'(temperature_i);
            count_d = count_q + 1'b1;
          end
          if (is_over) begin
            over_d = 1'b1;
            if (over_cnt_q != '1) over_cnt_d = over_cnt_q + 1'b1;
            run_d = run_inc;
            if (run_inc >= need) begin
              tripped_d  = 1'b1;
              div_needed = 1'b1;
            end
          end else begin
            run_d = '0;
          end
        end
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tms_pkg::ST_IDLE:   if (in_acc) state_d = div_needed ? tms_pkg::ST_LAUNCH : tms_pkg::ST_PEND;
      tms_pkg::ST_LAUNCH: state_d = tms_pkg::ST_DIV;
      tms_pkg::ST_DIV:    if (div_done) state_d = tms_pkg::ST_PEND;
      tms_pkg::ST_PEND:   if (!out_valid_q || out_ready_i) state_d = tms_pkg::ST_IDLE;
      default:            state_d = tms_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      tms_pkg::ST_IDLE:   in_ready_o = 1'b1;
      tms_pkg::ST_LAUNCH: div_start  = 1'b1;
      tms_pkg::ST_PEND:   out_load   = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // mean from magnitude of the sum, sign restored afterwards
  assign sum_mag = sum_q[SumBits-1] ? SumBits'(-sum_q) : SumBits'(sum_q);
  assign quo_low = quotient[TEMP_BITS-1:0];

  tms_div #(
    .DvdBits (SumBits),
    .DvsBits (COUNT_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_mag),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tms_pkg::ST_IDLE;
      limit_q     <= tms_pkg::LIMIT_RESET;
      trip_q      <= tms_pkg::TRIP_RESET;
      count_q     <= '0;
      over_cnt_q  <= '0;
      sum_q       <= '0;
      max_q       <= '0;
      min_q       <= '0;
      run_q       <= '0;
      tripped_q   <= 1'b0;
      stopped_q   <= 1'b0;
      over_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      limit_q     <= limit_d;
      trip_q      <= trip_d;
      count_q     <= count_d;
      over_cnt_q  <= over_cnt_d;
      sum_q       <= sum_d;
      max_q       <= max_d;
      min_q       <= min_d;
      run_q       <= run_d;
      tripped_q   <= tripped_d;
      stopped_q   <= stopped_d;
      over_q      <= over_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // stored mean, written at most once, when the divider finishes at the halt
  always_ff @(posedge clk_i) begin
    if (div_done) begin
      mean_q <= sum_q[SumBits-1] ? $signed(-quo_low) : $signed(quo_low);
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_over_q   <= over_q;
      o_run_q    <= run_q;
      o_shut_q   <= tripped_q;
      o_halt_q   <= halted;
      o_svalid_q <= (count_q != '0);
      o_count_q  <= count_q;
      o_above_q  <= over_cnt_q;
      o_max_q    <= max_q;
      o_min_q    <= min_q;
      o_mean_q   <= (halted && count_q != '0) ? mean_q : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign over_limit_o   = o_over_q;
  assign run_length_o   = o_run_q;
  assign shutdown_o     = o_shut_q;
  assign halted_o       = o_halt_q;
  assign stats_valid_o  = o_svalid_q;
  assign sample_total_o = o_count_q;
  assign above_total_o  = o_above_q;
  assign max_temp_o     = o_max_q;
  assign min_temp_o     = o_min_q;
  assign mean_temp_o    = o_mean_q;

  // divider only finishes while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == tms_pkg::ST_DIV)
    else $error("divider finished outside the divide state");

  // a trip always leaves a non-zero over-limit run behind
  a_trip_has_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tripped_q |-> run_q != '0)
    else $error("shutdown latched with an empty run");

  // over-limit samples never outnumber recorded samples
  a_over_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    over_cnt_q <= count_q)
    else $error("over-limit count exceeds sample count");

endmodule

// ===== tb/tb_temperature_monitor_trip_stats.sv =====
`timescale 1ns / 1ps

module tb_temperature_monitor_trip_stats;

  localparam int unsigned CNT_W       = 24;
  localparam int unsigned TMP_W       = 16;
  localparam int unsigned PHASE_ITEMS = 300;
  localparam int unsigned HALT_ITEMS  = 40;
  localparam int unsigned SETTLE      = 60;
  localparam int unsigned MAX_CYCLES  = 400_000;
  localparam int unsigned MAX_LOGGED  = 30;

  // one result as seen on the output ports
  typedef struct packed {
    logic                         over;
    logic [tms_pkg::RUN_BITS-1:0] run;
    logic                         shut;
    logic                         halt;
    logic                         sv;
    logic [CNT_W-1:0]             total;
    logic [CNT_W-1:0]             above;
    logic signed [TMP_W-1:0]      maxv;
    logic signed [TMP_W-1:0]      minv;
    logic signed [TMP_W-1:0]      mean;
  } reading_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_e;

  // directed row: a request or a register write, with an optional typed result
  typedef struct packed {
    row_e              kind;
    logic              sel;
    logic [TMP_W-1:0]  value;
    logic              typed;
    reading_t          want;
  } row_t;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_e;
  typedef enum {END_STOP, END_TRIP_ZERO, END_TRIP_FULL} ending_e;

  localparam reading_t NO_READING = '0;

  localparam row_t PLAN [22] = '{
    // first sample after reset sets both max and min
    '{ROW_REQ, tms_pkg::REQ_SAMPLE, 16'h0000, 1'b1,
      '{1'b0, 4'd0, 1'b0, 1'b0, 1'b1, 24'd1, 24'd0, 16'sh0000, 16'sh0000, 16'sh0000}},
    '{ROW_REQ, tms_pkg::REQ_SAMPLE, 16'h7FFF, 1'b1,
      '{1'b1, 4'd1, 1'b0, 1'b0, 1'b1, 24'd2, 24'd1, 16'sh7FFF, 16'sh0000, 16'sh0000}},
    '{ROW_REQ, tms_pkg::REQ_SAMPLE, 16'h8000, 1'b1,
      '{1'b0, 4'd0, 1'b0, 1'b0, 1'b1, 24'd3, 24'd1, 16'sh7FFF, 16'sh8000, 16'sh0000}},
    // equal to the limit is not over, then a run one short of the trip
    '{ROW_REQ, tms_pkg::REQ_SAMPLE, 16'd1280, 1'b0, NO_READING},
    '{ROW_REQ, tms_pkg::REQ_SAMPLE, 16'd1281, 1'b0, NO_READING},
    '{ROW_REQ, tms_pkg::REQ_SAMPLE, 16'd1281, 1'b0, NO_READING},
    '{ROW_REQ, tms_pkg::REQ_SAMPLE, 16'd0,    1'b0, NO_READING},
    // zero limit: any positive sample is over
    '{ROW_CFG, tms_pkg::CFG_TRIP_RUN,   16'd15,   1'b0, NO_READING},
    '{ROW_CFG, tms_pkg::CFG_TEMP_LIMIT, 16'd0,    1'b0, NO_READING},
    '{ROW_REQ, tms_pkg::REQ_SAMPLE,     16'd1,    1'b0, NO_READING},
    '{ROW_REQ, tms_pkg::REQ_SAMPLE,     16'd0,    1'b0, NO_READING},
    '{ROW_REQ, tms_pkg::REQ_SAMPLE,     16'hFFFF, 1'b0, NO_READING},
    // largest limit: nothing can exceed it
    '{ROW_CFG, tms_pkg::CFG_TEMP_LIMIT, 16'h7FFF, 1'b0, NO_READING},
    '{ROW_REQ, tms_pkg::REQ_SAMPLE,     16'h7FFF, 1'b0, NO_READING},
    '{ROW_REQ, tms_pkg::REQ_SAMPLE,     16'h5555, 1'b0, NO_READING},
    '{ROW_REQ, tms_pkg::REQ_SAMPLE,     16'hAAAA, 1'b0, NO_READING},
    // shortest trip run and a limit of one, staying under
    '{ROW_CFG, tms_pkg::CFG_TRIP_RUN,   16'd1,    1'b0, NO_READING},
    '{ROW_REQ, tms_pkg::REQ_SAMPLE,     16'hFFFB, 1'b0, NO_READING},
    '{ROW_CFG, tms_pkg::CFG_TEMP_LIMIT, 16'd1,    1'b0, NO_READING},
    '{ROW_REQ, tms_pkg::REQ_SAMPLE,     16'd1,    1'b0, NO_READING},
    '{ROW_CFG, tms_pkg::CFG_TRIP_RUN,   16'd15,   1'b0, NO_READING},
    '{ROW_REQ, tms_pkg::REQ_SAMPLE,     16'd2,    1'b0, NO_READING}
  };

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           cfg_valid_i   = 1'b0;
  logic                           cfg_ready_o;
  logic                           cfg_index_i   = tms_pkg::CFG_TEMP_LIMIT;
  logic [tms_pkg::LIMIT_BITS-1:0] cfg_data_i    = '0;
  logic                           in_valid_i    = 1'b0;
  logic                           in_ready_o;
  logic                           req_type_i    = tms_pkg::REQ_SAMPLE;
  logic signed [TMP_W-1:0]        temperature_i = '0;
  logic                           out_valid_o;
  logic                           out_ready_i   = 1'b0;
  logic                           over_limit_o;
  logic [tms_pkg::RUN_BITS-1:0]   run_length_o;
  logic                           shutdown_o;
  logic                           halted_o;
  logic                           stats_valid_o;
  logic [CNT_W-1:0]               sample_total_o;
  logic [CNT_W-1:0]               above_total_o;
  logic signed [TMP_W-1:0]        max_temp_o;
  logic signed [TMP_W-1:0]        min_temp_o;
  logic signed [TMP_W-1:0]        mean_temp_o;

  // monitor state mirrored by the predictor
  logic [tms_pkg::LIMIT_BITS-1:0] limit_reg    = tms_pkg::LIMIT_RESET;
  logic [tms_pkg::RUN_BITS-1:0]   trip_reg     = tms_pkg::TRIP_RESET;
  logic [CNT_W-1:0]               seen_count   = '0;
  longint                         temp_sum     = 0;
  logic signed [TMP_W-1:0]        peak_hi      = '0;
  logic signed [TMP_W-1:0]        peak_lo      = '0;
  logic [CNT_W-1:0]               above_count  = '0;
  logic [tms_pkg::RUN_BITS-1:0]   over_run     = '0;
  logic                           trip_latched = 1'b0;
  logic                           stop_latched = 1'b0;

  reading_t    expected_q [$];
  int unsigned send_idle    = 0;
  int unsigned recv_stall   = 0;
  int unsigned mismatches   = 0;
  int unsigned n_checked    = 0;
  int unsigned n_sent       = 0;
  int unsigned n_ignored    = 0;
  int unsigned cycles       = 0;

  temperature_monitor_trip_stats DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .temperature_i (temperature_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .over_limit_o  (over_limit_o),
    .run_length_o  (run_length_o),
    .shutdown_o    (shutdown_o),
    .halted_o      (halted_o),
    .stats_valid_o (stats_valid_o),
    .sample_total_o(sample_total_o),
    .above_total_o (above_total_o),
    .max_temp_o    (max_temp_o),
    .min_temp_o    (min_temp_o),
    .mean_temp_o   (mean_temp_o)
  );

  always #1 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == MAX_CYCLES) begin
      $display("FAIL temperature_monitor_trip_stats");
      $finish;
    end
  end

  // result side stalls
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall);
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    // keep the log short on a badly broken build
    if (mismatches <= MAX_LOGGED) $display("mismatch at result %0d: %s", n_checked, what);
  endtask

  task automatic compare_field(input string field, input longint got, input longint want);
    if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", field, got, want));
  endtask

  // next expected reading for one accepted request
  function automatic reading_t apply_request(input logic rtype,
                                             input logic signed [TMP_W-1:0] t);
    reading_t                     r;
    logic [tms_pkg::RUN_BITS-1:0] need;
    logic                         over;
    need = (trip_reg == 0) ? tms_pkg::RUN_BITS'(1) : trip_reg;
    over = 1'b0;
    if (!(trip_latched || stop_latched)) begin
      if (rtype == tms_pkg::REQ_STOP) begin
        stop_latched = 1'b1;
      end else begin
        if (seen_count == 0) begin
          peak_hi = t;
          peak_lo = t;
        end else begin
          if (t > peak_hi) peak_hi = t;
          if (t < peak_lo) peak_lo = t;
        end
        // sum freezes together with the count
        if (seen_count != '1) begin
          temp_sum   = temp_sum + longint'(t);
          seen_count = seen_count + 1'b1;
        end
        if (longint'(t) > longint'(limit_reg)) begin
          over = 1'b1;
          if (above_count != '1) above_count = above_count + 1'b1;
          if (over_run != tms_pkg::RUN_MAX) over_run = over_run + 1'b1;
          if (over_run >= need) trip_latched = 1'b1;
        end else begin
          over_run = '0;
        end
      end
    end
    r.over  = over;
    r.run   = over_run;
    r.shut  = trip_latched;
    r.halt  = trip_latched || stop_latched;
    r.sv    = (seen_count != 0);
    r.total = seen_count;
    r.above = above_count;
    r.maxv  = peak_hi;
    r.minv  = peak_lo;
    // mean truncates toward zero
    r.mean  = (r.halt && r.sv) ? TMP_W'(temp_sum / longint'(seen_count)) : '0;
    return r;
  endfunction

  // random sample that never completes a trip run
  function automatic logic signed [TMP_W-1:0] pick_sample();
    int                           t;
    logic [tms_pkg::RUN_BITS-1:0] need;
    need = (trip_reg == 0) ? tms_pkg::RUN_BITS'(1) : trip_reg;
    case ($urandom_range(5))
      0: t = int'($signed(16'($urandom)));
      1: begin
        case ($urandom_range(3))
          0:       t = 32767;
          1:       t = -32768;
          2:       t = 0;
          default: t = -1;
        endcase
      end
      2, 3: t = int'(limit_reg) + int'($urandom_range(6)) - 3;
      4: t = int'(limit_reg) + 1 + int'($urandom_range(32767 - int'(limit_reg)));
      default: t = int'($urandom_range(3000)) - 1000;
    endcase
    if (t > 32767) t = 32767;
    if (t > int'(limit_reg) && int'(over_run) + 1 >= int'(need)) begin
      t = ($urandom_range(1) != 0) ? int'(limit_reg) : -int'($urandom_range(32768));
    end
    return TMP_W'(t);
  endfunction

  task automatic send_request(input logic rtype, input logic signed [TMP_W-1:0] temp,
                              input logic typed, input reading_t typed_want);
    reading_t forecast;
    if (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_valid_i    <= 1'b0;
      req_type_i    <= 1'($urandom);
      temperature_i <= TMP_W'($urandom);
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= rtype;
    temperature_i <= temp;
    do @(posedge clk_i); while (!in_ready_o);
    if (trip_latched || stop_latched) n_ignored++;
    forecast = apply_request(rtype, temp);
    expected_q.push_back(typed ? typed_want : forecast);
    n_sent++;
  endtask

  // hold off new requests until every result is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_q.size() != 0);
  endtask

  task automatic write_reg(input logic idx, input logic [tms_pkg::LIMIT_BITS-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == tms_pkg::CFG_TEMP_LIMIT) limit_reg = data;
    else trip_reg = data[tms_pkg::RUN_BITS-1:0];
  endtask

  task automatic set_idling(input idle_e mode);
    send_idle  = (mode == IDLE_SENDER)   ? 70 : (mode == IDLE_BOTH) ? 10 : 0;
    recv_stall = (mode == IDLE_RECEIVER) ? 70 : (mode == IDLE_BOTH) ? 10 : 0;
  endtask

  // result checker
  always @(posedge clk_i) begin
    reading_t got;
    reading_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{over_limit_o, run_length_o, shutdown_o, halted_o, stats_valid_o,
              sample_total_o, above_total_o, max_temp_o, min_temp_o, mean_temp_o};
      if (expected_q.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = expected_q.pop_front();
        compare_field("over_limit",   got.over,  want.over);
        compare_field("run_length",   got.run,   want.run);
        compare_field("shutdown",     got.shut,  want.shut);
        compare_field("halted",       got.halt,  want.halt);
        compare_field("stats_valid",  got.sv,    want.sv);
        compare_field("sample_total", got.total, want.total);
        compare_field("above_total",  got.above, want.above);
        compare_field("max_temp",     got.maxv,  want.maxv);
        compare_field("min_temp",     got.minv,  want.minv);
        compare_field("mean_temp",    got.mean,  want.mean);
      end
      n_checked++;
    end
  end

  initial begin
    ending_e ending;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(PLAN[i].sel, PLAN[i].value[tms_pkg::LIMIT_BITS-1:0]);
      end else begin
        send_request(PLAN[i].sel, PLAN[i].value, PLAN[i].typed, PLAN[i].want);
      end
    end

    // random phases, each with its own settings and idling pattern
    for (int m = 0; m < 4; m++) begin
      drain_results();
      case (m)
        0: begin
          write_reg(tms_pkg::CFG_TEMP_LIMIT, tms_pkg::LIMIT_RESET);
          write_reg(tms_pkg::CFG_TRIP_RUN, tms_pkg::LIMIT_BITS'(tms_pkg::TRIP_RESET));
        end
        1: begin
          write_reg(tms_pkg::CFG_TEMP_LIMIT, tms_pkg::LIMIT_BITS'(32767));
          write_reg(tms_pkg::CFG_TRIP_RUN, tms_pkg::LIMIT_BITS'(15));
        end
        2: begin
          write_reg(tms_pkg::CFG_TEMP_LIMIT, tms_pkg::LIMIT_BITS'(1));
          write_reg(tms_pkg::CFG_TRIP_RUN, tms_pkg::LIMIT_BITS'(2));
        end
        default: begin
          write_reg(tms_pkg::CFG_TEMP_LIMIT, tms_pkg::LIMIT_BITS'($urandom_range(32767, 1)));
          write_reg(tms_pkg::CFG_TRIP_RUN, tms_pkg::LIMIT_BITS'($urandom_range(15, 1)));
        end
      endcase
      set_idling(idle_e'(m));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2) drain_results();
        send_request(tms_pkg::REQ_SAMPLE, pick_sample(), 1'b0, NO_READING);
      end
    end

    // halt the block one way or another, then keep knocking
    ending = ending_e'($urandom_range(2));
    drain_results();
    if (ending != END_STOP) begin
      write_reg(tms_pkg::CFG_TEMP_LIMIT, tms_pkg::LIMIT_BITS'($urandom_range(32000, 1)));
      write_reg(tms_pkg::CFG_TRIP_RUN, (ending == END_TRIP_ZERO) ?
                tms_pkg::LIMIT_BITS'(0) : tms_pkg::LIMIT_BITS'(15));
    end
    set_idling(idle_e'($urandom_range(3)));
    case (ending)
      END_STOP: send_request(tms_pkg::REQ_STOP, TMP_W'($urandom), 1'b0, NO_READING);
      END_TRIP_ZERO: begin
        // zero trip run acts as one: the first over-limit sample trips
        repeat (3) send_request(tms_pkg::REQ_SAMPLE, pick_sample(), 1'b0, NO_READING);
        send_request(tms_pkg::REQ_SAMPLE,
                     TMP_W'(int'(limit_reg) + 1 + int'($urandom_range(32766 - int'(limit_reg)))),
                     1'b0, NO_READING);
      end
      default: begin
        // full run to the saturation point of the run counter
        repeat (15) begin
          send_request(tms_pkg::REQ_SAMPLE,
                       TMP_W'(int'(limit_reg) + 1 +
                              int'($urandom_range(32766 - int'(limit_reg)))),
                       1'b0, NO_READING);
        end
      end
    endcase
    repeat (HALT_ITEMS) send_request(1'($urandom), TMP_W'($urandom), 1'b0, NO_READING);

    drain_results();
    repeat (SETTLE) @(posedge clk_i);
    if (expected_q.size() != 0) report_mismatch("results still outstanding at the end");

    $display("%0d requests (%0d after halt), %0d results checked, %0d mismatches",
             n_sent, n_ignored, n_checked, mismatches);
    $display("limit and trip run swept to their extremes; block halted by %s", ending.name());
    if (mismatches == 0) begin
      $display("PASS temperature_monitor_trip_stats");
    end else begin
      $display("FAIL temperature_monitor_trip_stats");
    end
    $finish;
  end

endmodule

// ===== temperature_monitor_trip_stats.f =====
src/tms_pkg.sv
src/tms_div.sv
src/temperature_monitor_trip_stats.sv
tb/tb_temperature_monitor_trip_stats.sv
